// File: rtl/core/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 core.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int WordW   = 32;
  localparam int Rounds  = 64;

  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [WordW-1:0] word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       put_byte;   // write in_byte at pos
    logic [7:0] in_byte;
    logic [5:0] pos;
    logic       zero_tail;  // clear words after pos
    logic       zero_all;   // clear whole block
    logic       put_len;    // write bit length into words 14, 15
    logic       cnt_inc;
    logic       cnt_clr;
    logic       load_work;  // copy chaining value into working vars
    logic       round;      // one round at index rnd
    logic [5:0] rnd;
    logic       fold;       // add working vars into chaining value
    logic       iv_load;    // chaining value back to IV
  } sha_cmd_t;

  typedef struct packed {
    logic [63:0] byte_count;
  } sha_stat_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage

// File: rtl/core/sha_datapath.sv
// Datapath: block buffer, rolling schedule, working variables, chaining value.
`timescale 1ns / 1ps
module sha_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [2:0]        rd_idx,
  output sha_pkg::word_t    rd_word,
  output sha_pkg::sha_stat_t stat
);

  sha_pkg::word_t blk_r [16];   // block buffer, doubles as the rolling schedule
  sha_pkg::word_t wv_r  [8];    // a..h
  sha_pkg::word_t hv_r  [8];
  logic [63:0]    cnt_r;

  function automatic sha_pkg::word_t ror(input sha_pkg::word_t v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  sha_pkg::word_t w_t, w_new, t1, t2, s0, s1, big0, big1, ch, maj;
  logic [3:0]     widx;
  logic [4:0]     sh;
  logic [63:0]    bits;

  always_comb begin
    // rounds 0..15 read the buffer as is; later rounds read the freshly expanded word
    s0    = ror(blk_r[1], 7) ^ ror(blk_r[1], 18) ^ (blk_r[1] >> 3);
    s1    = ror(blk_r[14], 17) ^ ror(blk_r[14], 19) ^ (blk_r[14] >> 10);
    w_new = s1 + blk_r[9] + s0 + blk_r[0];
    w_t   = (cmd.rnd < 6'd16) ? blk_r[cmd.rnd[3:0]] : w_new;
    big1  = ror(wv_r[4], 6) ^ ror(wv_r[4], 11) ^ ror(wv_r[4], 25);
    ch    = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    t1    = wv_r[7] + big1 + ch + sha_pkg::round_k(cmd.rnd) + w_t;
    big0  = ror(wv_r[0], 2) ^ ror(wv_r[0], 13) ^ ror(wv_r[0], 22);
    maj   = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t2    = big0 + maj;
    widx  = cmd.pos[5:2];
    sh    = 5'd24 - {cmd.pos[1:0], 3'd0};
    bits  = {cnt_r[60:0], 3'd0};
  end

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      if (cmd.pos[1:0] == 2'd0) blk_r[widx] <= {cmd.in_byte, 24'd0};
      else blk_r[widx] <= blk_r[widx] | (sha_pkg::word_t'(cmd.in_byte) << sh);
    end
    if (cmd.zero_tail) begin
      for (int k = 0; k < 16; k++) if (4'(k) > widx) blk_r[k] <= '0;
    end
    if (cmd.zero_all) begin
      for (int k = 0; k < 16; k++) blk_r[k] <= '0;
    end
    if (cmd.put_len) begin
      blk_r[14] <= bits[63:32];
      blk_r[15] <= bits[31:0];
    end
    // from round 16 on the window slides, keeping W[t-15..t]
    if (cmd.round && cmd.rnd >= 6'd16) begin
      for (int k = 0; k < 15; k++) blk_r[k] <= blk_r[k+1];
      blk_r[15] <= w_new;
    end
    if (cmd.load_work) begin
      for (int k = 0; k < 8; k++) wv_r[k] <= hv_r[k];
    end
    if (cmd.round) begin
      wv_r[7] <= wv_r[6]; wv_r[6] <= wv_r[5]; wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2]; wv_r[2] <= wv_r[1]; wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.iv_load) begin
      for (int k = 0; k < 8; k++) hv_r[k] <= sha_pkg::init_hash(3'(k));
    end else if (cmd.fold) begin
      for (int k = 0; k < 8; k++) hv_r[k] <= hv_r[k] + wv_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) cnt_r <= '0;
    else if (cmd.cnt_inc) cnt_r <= cnt_r + 64'd1;
  end

  assign rd_word = hv_r[rd_idx];
  assign stat.byte_count = cnt_r;

endmodule

// File: rtl/core/sha_ctrl.sv
// Controller: byte intake, padding sequence, round counter and digest readout.
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_byte,
  input  logic               in_present,
  input  logic               in_end,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [2:0]         out_idx,
  output sha_pkg::sha_cmd_t  cmd,
  input  sha_pkg::sha_stat_t stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;  // place 0x80 and clear tail
  localparam logic [2:0] S_LEN   = 3'd2;  // write length field
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // what follows a compression
  localparam logic [1:0] N_IDLE = 2'd0;
  localparam logic [1:0] N_PAD2 = 2'd1;  // overflow: zero block then length
  localparam logic [1:0] N_OUT  = 2'd2;
  localparam logic [1:0] N_PAD  = 2'd3;  // full block came with end flag

  logic [2:0] st_r, st_nxt;
  logic [1:0] nx_r, nx_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [5:0] pos;
  logic       acc;

  assign pos       = stat.byte_count[5:0];
  assign in_tready = (st_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign out_tvalid = (st_r == S_OUT);
  assign out_idx   = idx_r;

  always_comb begin
    st_nxt  = st_r;
    nx_nxt  = nx_r;
    rnd_nxt = rnd_r;
    idx_nxt = idx_r;
    cmd     = '0;
    cmd.pos = pos;
    cmd.rnd = rnd_r;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          if (in_present) begin
            cmd.put_byte = 1'b1;
            cmd.in_byte  = in_byte;
            cmd.cnt_inc  = 1'b1;
            if (pos == 6'd63) begin
              cmd.load_work = 1'b1;
              rnd_nxt = '0;
              st_nxt  = S_ROUND;
              nx_nxt  = in_end ? N_PAD : N_IDLE;
            end else if (in_end) begin
              st_nxt = S_PAD;
            end
          end else if (in_end) begin
            st_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.put_byte  = 1'b1;
        cmd.in_byte   = sha_pkg::PadByte;
        cmd.zero_tail = 1'b1;
        cmd.load_work = 1'b1;
        rnd_nxt = '0;
        if (pos >= 6'd56) begin
          st_nxt = S_ROUND;
          nx_nxt = N_PAD2;
        end else begin
          st_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.put_len   = 1'b1;
        cmd.load_work = 1'b1;
        rnd_nxt = '0;
        st_nxt  = S_ROUND;
        nx_nxt  = N_OUT;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'(sha_pkg::Rounds - 1)) st_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        case (nx_r)
          N_IDLE: st_nxt = S_IDLE;
          N_PAD:  st_nxt = S_PAD;
          N_PAD2: begin
            cmd.zero_all = 1'b1;
            st_nxt = S_LEN;
          end
          default: begin
            idx_nxt = '0;
            st_nxt  = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (out_tready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.iv_load = 1'b1;
            cmd.cnt_clr = 1'b1;
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      nx_r  <= N_IDLE;
      rnd_r <= '0;
      idx_r <= '0;
    end else begin
      st_r  <= st_nxt;
      nx_r  <= nx_nxt;
      rnd_r <= rnd_nxt;
      idx_r <= idx_nxt;
    end
  end

  a_rnd_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_ROUND) && (st_nxt == S_ROUND) |=> rnd_r == 6'd0)
    else $error("round counter not cleared at compression start");
  a_fold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FOLD |-> $past(st_r) == S_ROUND && $past(rnd_r) == 6'd63)
    else $error("fold without 64 rounds");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_tready)
    else $error("input taken while busy");
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_OUT && out_tready && idx_r == 3'd7 |=> st_r == S_IDLE &&
    stat.byte_count == 64'd0)
    else $error("no return to idle after digest");

endmodule

// File: rtl/core/sha256_hash_core.sv
// Top level of the streaming SHA-256 core.
`timescale 1ns / 1ps
// SHA-256 over a byte stream. Each input transfer carries one byte (if
// in_tuser[0], byte present) and may close the message (in_tlast). The 64th
// byte of a block starts a compression of 64 rounds, one per cycle on a
// single round unit, then a fold into the chaining value; in_tready stays
// low during the rounds and the fold.
// On an end transfer the core pads the message, runs one or two more
// compressions (two when 56 or more bytes of the last block are used), then
// presents the eight digest words H0..H7 as eight output transfers, with
// out_tlast on H7. After the last word the chaining value returns to the IV
// and the byte count to zero. No input is taken while the digest is shown.
module sha256_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast   // last_word
);

  sha_pkg::sha_cmd_t  cmd;
  sha_pkg::sha_stat_t stat;
  logic [2:0]         idx;
  sha_pkg::word_t     word;

  sha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_byte(in_tdata), .in_present(in_tuser), .in_end(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_idx(idx),
    .cmd(cmd), .stat(stat)
  );

  sha_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .rd_idx(idx), .rd_word(word), .stat(stat)
  );

  assign out_tdata = {5'd0, idx, word};
  assign out_tlast = (idx == 3'd7);

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the streaming SHA-256 core.
`timescale 1ns / 1ps
// Drives byte transfers into sha256_hash_core and computes the digest of each
// message with an independent SHA-256 model. Each output transfer is checked
// against the oldest expected digest word. The directed messages cover the
// empty message, 55/56/64 byte padding edges and an end marker with and
// without a byte. Three random phases follow, both idling in the first two.

class digest_board;
  logic [31:0] hash_st[8];
  logic [31:0] blk[16];
  logic [63:0] nbytes;
  logic [34:0] pending[$];   // {word_index, digest_word}
  logic        last_q[$];
  int          errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    hash_st = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    nbytes = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function void compress();
    logic [31:0] kc[64];
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    kc = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    for (int t = 0; t < 64; t++) begin
      if (t < 16) w[t] = blk[t];
      else w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    end
    {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + kc[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endfunction

  function void place(int pos, logic [7:0] v);
    if (pos % 4 == 0) blk[pos/4] = {v, 24'h0};
    else blk[pos/4][31 - 8*(pos%4) -: 8] = v;
  endfunction

  // Note one accepted input transfer.
  function void note_input(logic [7:0] data, logic present, logic ending);
    int pos;
    if (present) begin
      place(int'(nbytes[5:0]), data);
      nbytes++;
      if (nbytes[5:0] == 0) compress();
    end
    if (!ending) return;
    pos = int'(nbytes[5:0]);
    place(pos, 8'h80);
    for (int k = pos/4 + 1; k < 16; k++) blk[k] = '0;
    if (pos >= 56) begin
      compress();
      for (int k = 0; k < 16; k++) blk[k] = '0;
    end
    {blk[14], blk[15]} = nbytes << 3;
    compress();
    for (int k = 0; k < 8; k++) begin
      pending.push_back({3'(k), hash_st[k]});
      last_q.push_back(k == 7);
    end
    restart();
  endfunction

  // Check one output transfer against the oldest expected word.
  function void check_word(logic [39:0] data, logic last);
    logic [34:0] exp_w;
    logic        exp_l;
    if (pending.size() == 0) begin
      $display("%0t: unexpected digest word %h", $time, data);
      errors++;
      return;
    end
    exp_w = pending.pop_front();
    exp_l = last_q.pop_front();
    if (data[31:0] !== exp_w[31:0]) begin
      $display("%0t: digest_word exp %h got %h", $time, exp_w[31:0], data[31:0]);
      errors++;
    end
    if (data[34:32] !== exp_w[34:32]) begin
      $display("%0t: word_index exp %0d got %0d", $time, exp_w[34:32], data[34:32]);
      errors++;
    end
    if (last !== exp_l) begin
      $display("%0t: last_word exp %b got %b", $time, exp_l, last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] byte_present
  logic        in_tlast;   // end_of_message
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] digest_word, [34:32] word_index
  logic        out_tlast;  // last_word

  localparam int StallLimit = 20000;

  digest_board board;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  stall_cycles;
  int  items_sent;
  bit  timed_out;

  sha256_hash_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver side: random backpressure, checks every output transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) board.check_word(out_tdata, out_tlast);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_top failed");
      $finish;
    end
  end

  // One input transfer, with random idle cycles ahead of it. tvalid stays
  // high after the transfer until the next idle cycle or the end of stimulus.
  task automatic send_item(logic [7:0] data, logic present, logic ending);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= present;
    in_tlast  <= ending;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(data, present, ending);
    items_sent++;
  endtask

  // Message of nbytes random or 0xff bytes; stray idle items mixed in, end marker
  // either rides on the last byte or stands alone.
  task automatic send_message(int nbytes, bit fill_ff);
    bit alone;
    alone = (nbytes == 0) || $urandom_range(1);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(fill_ff ? 8'hff : 8'($urandom), 1'b1, !alone && i == nbytes - 1);
    end
    if (alone) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int sizes[$];
    int start;
    board = new();
    timed_out = 1'b0;
    stall_cycles = 0;
    items_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 79;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, zero and all-ones bytes, padding edges.
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_message(3, 1'b1);
    sizes = '{55, 56, 64};
    foreach (sizes[i]) send_message(sizes[i], 1'b0);

    // Random: three phases, idling in the first two; mostly short messages, a few long ones.
    start = items_sent;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 79 : 0;
      recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 35 : 0;
      while (items_sent < start + 42 * (ph + 1)) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(20);
        send_message(n, 1'b0);
      end
    end
    in_tvalid <= 1'b0;

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/sha_pkg.sv
rtl/core/sha_datapath.sv
rtl/core/sha_ctrl.sv
rtl/core/sha256_hash_core.sv
test/tb_top.sv
